// ----- hw/rtl/iida_pkg.sv -----
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and constants for the indexed insert/delete array unit:
// store geometry, request codes and status codes.
// ----------------------------------------------------------------------------
package iida_pkg;

  // Store geometry, fixed by the port widths
  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2,
    MODE_RESIZE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_POS  = 2'd2,
    STATUS_BAD_SIZE = 2'd3
  } status_t;

endpackage

// ----- hw/rtl/indexed_insert_delete_array_unit.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_unit
// Ordered store of 16 signed words with insert, delete, dump and resize,
// driven by a small sequencer around one shared index step unit.
// ----------------------------------------------------------------------------
// The unit takes one request beat at a time and is stalled until that request
// has finished its work. Insert moves one entry up per cycle, from the end of
// the store down to the target position, then writes the new word and then
// presents the status beat. Delete moves one entry down per cycle from the
// target position, then presents the status beat. Both are paced by the
// single read/write port of the entry store and the one shared index
// incrementer/decrementer. Dump presents one beat per cycle while the output
// register is free, one per entry in use, with last set on the final entry;
// an empty store gives a single beat without a word. Resize and any rejected
// request give one status beat. Result beats sit in an output register, so
// the next request is taken while the final result beat of the previous one
// still waits. The store clears at reset; slots brought back into use by a
// resize keep the bits they held before, and a slot vacated by a delete
// keeps a copy of its neighbour.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [4:0]                    in_position,
  input  logic signed [31:0]            in_value,
  input  logic [4:0]                    in_new_size,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_word,
  output logic [3:0]                    out_slot,
  output logic [4:0]                    out_count,
  output logic [1:0]                    out_status,
  output logic                          out_has_word,
  output logic                          out_last
);
  import iida_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL,
    ST_DUMP,
    ST_RESP
  } state_t;

  localparam cnt_t CAP_CNT = CNT_W'(CAPACITY);

  // Sequencer state and request context
  state_t  state_r,  state_nxt;
  idx_t    idx_r,    idx_nxt;
  cnt_t    used_r,   used_nxt;
  idx_t    pos_r,    pos_nxt;
  word_t   val_r,    val_nxt;
  status_t status_r, status_nxt;

  // Output register
  logic    out_valid_r,    out_valid_nxt;
  word_t   out_word_r,     out_word_nxt;
  idx_t    out_slot_r,     out_slot_nxt;
  cnt_t    out_count_r,    out_count_nxt;
  status_t out_status_r,   out_status_nxt;
  logic    out_has_word_r, out_has_word_nxt;
  logic    out_last_r,     out_last_nxt;

  // Entry store: one read and one write per cycle
  word_t   entries_r [CAPACITY];
  logic    wr_en;
  idx_t    wr_idx;
  word_t   wr_data;
  idx_t    rd_idx;
  word_t   rd_data;

  // Shared index step unit
  idx_t    idx_step;
  cnt_t    idx_plus1;

  logic    in_acc;
  logic    out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  // Output register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Insert walks downwards, delete and dump walk upwards
  assign idx_step  = (state_r == ST_INS) ? idx_r - idx_t'(1) : idx_r + idx_t'(1);
  assign idx_plus1 = {1'b0, idx_r} + cnt_t'(1);
  // Insert and delete copy from the neighbour, dump reads the current slot
  assign rd_idx    = (state_r == ST_DUMP) ? idx_r : idx_step;
  assign rd_data   = entries_r[rd_idx];

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    used_nxt         = used_r;
    pos_nxt          = pos_r;
    val_nxt          = val_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_word_nxt     = out_word_r;
    out_slot_nxt     = out_slot_r;
    out_count_nxt    = out_count_r;
    out_status_nxt   = out_status_r;
    out_has_word_nxt = out_has_word_r;
    out_last_nxt     = out_last_r;
    wr_en            = 1'b0;
    wr_idx           = idx_r;
    wr_data          = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt    = in_position[IDX_W-1:0];
          val_nxt    = word_t'(in_value);
          status_nxt = STATUS_OK;
          unique case (mode_t'(in_mode))
            MODE_INSERT: begin
              if (used_r == CAP_CNT) begin
                status_nxt = STATUS_FULL;
                state_nxt  = ST_RESP;
              end else if (in_position > used_r) begin
                status_nxt = STATUS_BAD_POS;
                state_nxt  = ST_RESP;
              end else begin
                idx_nxt   = used_r[IDX_W-1:0];
                state_nxt = ST_INS;
              end
            end
            MODE_DELETE: begin
              if (in_position >= used_r) begin
                status_nxt = STATUS_BAD_POS;
                state_nxt  = ST_RESP;
              end else begin
                idx_nxt   = in_position[IDX_W-1:0];
                state_nxt = ST_DEL;
              end
            end
            MODE_DUMP: begin
              if (used_r == '0) begin
                state_nxt = ST_RESP;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_DUMP;
              end
            end
            MODE_RESIZE: begin
              if (in_new_size > CAP_CNT) begin
                status_nxt = STATUS_BAD_SIZE;
              end else begin
                used_nxt = in_new_size;
              end
              state_nxt = ST_RESP;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end

      ST_INS: begin
        // Move one entry up per cycle, then drop the new word into place
        wr_en = 1'b1;
        if (idx_r > pos_r) begin
          wr_data = rd_data;
          idx_nxt = idx_step;
        end else begin
          wr_data   = val_r;
          used_nxt  = used_r + cnt_t'(1);
          state_nxt = ST_RESP;
        end
      end

      ST_DEL: begin
        // Move one entry down per cycle until the end of the used range
        if (idx_plus1 < used_r) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          idx_nxt = idx_step;
        end else begin
          used_nxt  = used_r - cnt_t'(1);
          state_nxt = ST_RESP;
        end
      end

      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_word_nxt     = rd_data;
          out_slot_nxt     = idx_r;
          out_count_nxt    = used_r;
          out_status_nxt   = STATUS_OK;
          out_has_word_nxt = 1'b1;
          out_last_nxt     = (idx_plus1 == used_r);
          if (idx_plus1 == used_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_step;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_word_nxt     = '0;
          out_slot_nxt     = '0;
          out_count_nxt    = used_r;
          out_status_nxt   = status_r;
          out_has_word_nxt = 1'b0;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r          <= idx_nxt;
    pos_r          <= pos_nxt;
    val_r          <= val_nxt;
    status_r       <= status_nxt;
    out_word_r     <= out_word_nxt;
    out_slot_r     <= out_slot_nxt;
    out_count_r    <= out_count_nxt;
    out_status_r   <= out_status_nxt;
    out_has_word_r <= out_has_word_nxt;
    out_last_r     <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '{default: '0};
    end else if (wr_en) begin
      entries_r[wr_idx] <= wr_data;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign out_slot     = out_slot_r;
  assign out_count    = out_count_r;
  assign out_status   = out_status_r;
  assign out_has_word = out_has_word_r;
  assign out_last     = out_last_r;

endmodule

// ----- test/indexed_insert_delete_array_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_checker
// Watches both channels of the array unit, keeps its own copy of the store,
// predicts every result beat and compares each one with the prediction.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [4:0]         in_position,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_new_size,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_word,
  input  logic [3:0]         out_slot,
  input  logic [4:0]         out_count,
  input  logic [1:0]         out_status,
  input  logic               out_has_word,
  input  logic               out_last,
  output logic [31:0]        mismatches,
  output logic [31:0]        pending,
  output logic [31:0]        fill_now,
  output logic [31:0]        requests,
  output logic [31:0]        results
);
  import iida_pkg::*;

  typedef struct {
    word_t   word;
    idx_t    slot;
    cnt_t    count;
    status_t status;
    logic    has_word;
    logic    last;
  } result_beat_t;

  word_t        shadow_cells [CAPACITY];
  int           shadow_fill;
  result_beat_t expected_beats [$];
  result_beat_t head;

  initial begin
    mismatches = '0;
    pending    = '0;
    fill_now   = '0;
    requests   = '0;
    results    = '0;
  end

  task automatic queue_beat(input word_t w, input int s, input status_t st,
                            input logic hw, input logic lst);
    result_beat_t b;
    b.word     = w;
    b.slot     = idx_t'(s);
    b.count    = cnt_t'(shadow_fill);
    b.status   = st;
    b.has_word = hw;
    b.last     = lst;
    expected_beats.push_back(b);
  endtask

  // Apply one request to the shadow store and queue the beats it causes
  task automatic predict_request(input mode_t m, input int p, input word_t v,
                                 input int s);
    status_t st;
    int      i;
    st = STATUS_OK;
    case (m)
      MODE_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          st = STATUS_FULL;
        end else if (p > shadow_fill) begin
          st = STATUS_BAD_POS;
        end else begin
          for (i = shadow_fill; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[p] = v;
          shadow_fill++;
        end
      end
      MODE_DELETE: begin
        if (p >= shadow_fill) begin
          st = STATUS_BAD_POS;
        end else begin
          for (i = p; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_fill--;
        end
      end
      MODE_DUMP: begin
        if (shadow_fill == 0) begin
          queue_beat('0, 0, STATUS_OK, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < shadow_fill; i++)
            queue_beat(shadow_cells[i], i, STATUS_OK, 1'b1, i + 1 == shadow_fill);
        end
      end
      default: begin
        if (s > CAPACITY) st = STATUS_BAD_SIZE;
        else shadow_fill = s;
      end
    endcase
    if (m != MODE_DUMP) queue_beat('0, 0, st, 1'b0, 1'b1);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("field %s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CAPACITY; k++) shadow_cells[k] = '0;
      shadow_fill = 0;
      expected_beats.delete();
    end else begin
      // compare the result beat first: it always belongs to an older request
      if (out_valid && !out_stall) begin
        results++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: word %h", out_word);
          mismatches++;
        end else begin
          head = expected_beats.pop_front();
          check_field("word", head.word, out_word);
          check_field("slot", 32'(head.slot), 32'(out_slot));
          check_field("count", 32'(head.count), 32'(out_count));
          check_field("status", 32'(head.status), 32'(out_status));
          check_field("has_word", 32'(head.has_word), 32'(out_has_word));
          check_field("last", 32'(head.last), 32'(out_last));
        end
      end
      if (in_valid && !in_stall) begin
        requests++;
        predict_request(mode_t'(in_mode), int'(in_position), in_value,
                        int'(in_new_size));
      end
    end
    pending  = expected_beats.size();
    fill_now = shadow_fill;
  end

endmodule

// ----- test/indexed_insert_delete_array_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_unit_test
// Drives the array unit with directed corner cases and then random requests
// under four idling patterns; the checker beside the unit judges every beat.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_unit_test;
  import iida_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 37;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic [4:0]         in_position;
  logic signed [31:0] in_value;
  logic [4:0]         in_new_size;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_word;
  logic [3:0]         out_slot;
  logic [4:0]         out_count;
  logic [1:0]         out_status;
  logic               out_has_word;
  logic               out_last;

  logic [31:0] mismatches;
  logic [31:0] pending;
  logic [31:0] fill_now;
  logic [31:0] requests;
  logic [31:0] results;

  // Idling percentages for the current phase
  int send_idle_pct;
  int recv_stall_pct;
  // Entry count as seen at the last falling edge; lags one request at most
  int fill_seen;
  int quiet_cycles;

  indexed_insert_delete_array_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_position  (in_position),
    .in_value     (in_value),
    .in_new_size  (in_new_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .out_slot     (out_slot),
    .out_count    (out_count),
    .out_status   (out_status),
    .out_has_word (out_has_word),
    .out_last     (out_last)
  );

  indexed_insert_delete_array_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_position  (in_position),
    .in_value     (in_value),
    .in_new_size  (in_new_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .out_slot     (out_slot),
    .out_count    (out_count),
    .out_status   (out_status),
    .out_has_word (out_has_word),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .pending      (pending),
    .fill_now     (fill_now),
    .requests     (requests),
    .results      (results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random at the current phase's rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sample the predicted count at the falling edge, where it has settled
  always @(negedge clk) begin
    fill_seen <= int'(fill_now);
  end

  // Watchdog: abort when neither channel has moved a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one request beat, after an optional random idle stretch, and hold
  // it until the unit takes it. Returns at the accepting edge.
  task automatic send_request(input mode_t m, input logic [4:0] pos,
                              input logic [31:0] val, input logic [4:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_position <= pos;
    in_value    <= val;
    in_new_size <= size;
    // stall is steady between the falling edge and the next rising edge
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Mostly well-formed requests against the current count, with a tenth of
  // positions and sizes drawn from the whole field to hit the error paths
  task automatic random_request();
    int          pick;
    int          top_pos;
    logic [4:0]  pos;
    logic [4:0]  size;
    mode_t       m;
    pick    = $urandom_range(99);
    pos     = 5'($urandom_range(31));
    size    = 5'($urandom_range(31));
    if (pick < 40) begin
      m = MODE_INSERT;
      if ($urandom_range(9) != 0) pos = 5'($urandom_range(fill_seen));
    end else if (pick < 65) begin
      m       = MODE_DELETE;
      top_pos = (fill_seen > 0) ? fill_seen - 1 : 0;
      if ($urandom_range(9) != 0) pos = 5'($urandom_range(top_pos));
    end else if (pick < 77) begin
      m = MODE_DUMP;
    end else begin
      m = MODE_RESIZE;
      if ($urandom_range(9) != 0) size = 5'($urandom_range(CAPACITY));
    end
    send_request(m, pos, $urandom, size);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) random_request();
    drain_results();
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= MODE_INSERT;
    in_position <= '0;
    in_value    <= '0;
    in_new_size <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty store, cleared contents, full store, bad sizes,
    // bad positions, extreme words and the copy left behind by a delete
    send_request(MODE_DUMP,   5'd0,  32'h0,        5'd0);   // dump while empty
    send_request(MODE_DELETE, 5'd0,  32'h0,        5'd0);   // delete while empty
    send_request(MODE_RESIZE, 5'd0,  32'h0,        5'd16);  // grow to capacity
    send_request(MODE_DUMP,   5'd0,  32'h0,        5'd0);   // reset contents
    send_request(MODE_INSERT, 5'd0,  32'h12345678, 5'd0);   // insert when full
    send_request(MODE_RESIZE, 5'd0,  32'h0,        5'd31);  // size too large
    send_request(MODE_RESIZE, 5'd0,  32'h0,        5'd17);  // just over capacity
    send_request(MODE_RESIZE, 5'd31, 32'hFFFFFFFF, 5'd0);   // shrink to nothing
    send_request(MODE_INSERT, 5'd1,  32'h1,        5'd0);   // insert past the end
    send_request(MODE_INSERT, 5'd0,  32'h7FFFFFFF, 5'd31);
    send_request(MODE_INSERT, 5'd1,  32'h80000000, 5'd0);   // append
    send_request(MODE_INSERT, 5'd0,  32'hFFFFFFFF, 5'd0);   // insert at the front
    send_request(MODE_INSERT, 5'd1,  32'h00000000, 5'd0);
    send_request(MODE_DUMP,   5'd0,  32'h0,        5'd0);
    send_request(MODE_DELETE, 5'd4,  32'h0,        5'd0);   // delete just past the end
    send_request(MODE_DELETE, 5'd31, 32'h0,        5'd0);   // delete far off
    send_request(MODE_DELETE, 5'd0,  32'h0,        5'd0);
    send_request(MODE_RESIZE, 5'd0,  32'h0,        5'd4);   // reveal vacated slot
    send_request(MODE_DUMP,   5'd0,  32'h0,        5'd0);
    send_request(MODE_INSERT, 5'd31, 32'hA5A5A5A5, 5'd0);
    send_request(MODE_DELETE, 5'd3,  32'h0,        5'd0);   // delete the last
    send_request(MODE_RESIZE, 5'd0,  32'h0,        5'd16);
    send_request(MODE_DUMP,   5'd0,  32'h0,        5'd0);
    drain_results();

    // Random part: no idling, sender idle, receiver stalling, both
    run_phase(0, 0);
    run_phase(77, 0);
    run_phase(0, 77);
    run_phase(25, 25);

    // Let any stray beat surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d result beats: empty, full, bad position",
             requests, results);
    $display("and bad size cases, dumps up to full capacity, under four idling patterns.");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
